FILE: sv/brc_pkg.sv
package brc_pkg;

    // colour register file
    localparam int COLOUR_COUNT = 32;
    localparam int SLOT_W       = $clog2(COLOUR_COUNT);
    localparam int RGB_W        = 12;
    localparam int NIB_W        = 4;

    // stream and configuration widths
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int POS_W        = 9;
    localparam int PLANE_W      = 6;
    localparam int PCOUNT_W     = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // each channel halved keeps three bits per nibble
    localparam logic [RGB_W-1:0] HALF_MASK = 12'h777;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DUAL_PF    = 3'd0,
        REG_HAM_EN     = 3'd1,
        REG_PF2_FRONT  = 3'd2,
        REG_HWIN_START = 3'd3,
        REG_HWIN_STOP  = 3'd4
    } cfg_reg_t;

    // work carried from front to back
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_BLANK,
        OP_LOOKUP,
        OP_HALF,
        OP_HAM
    } op_t;

    // hold-and-modify control from the two top plane bits
    typedef enum logic [1:0] {
        HAM_LOAD  = 2'd0,
        HAM_BLUE  = 2'd1,
        HAM_RED   = 2'd2,
        HAM_GREEN = 2'd3
    } ham_ctl_t;

    typedef struct packed {
        op_t               op;
        logic              line_start;
        logic [SLOT_W-1:0] idx;
        ham_ctl_t          ham_ctl;
        logic [RGB_W-1:0]  value;
    } item_t;

endpackage

FILE: sv/bitplane_colour_resolver.sv
// bitplane colour resolver
// s_* carries items: tuser 0 is a pixel column, tuser 1 writes colour register
// colour_slot with colour_value. a pixel gives one transfer on m_* holding the
// 12-bit rgb colour; a colour write gives nothing.
// cfg_* writes the mode and window registers (0 dual playfield, 1 ham enable,
// 2 playfield two in front, 3 window start, 4 window stop); cfg_ready is
// always high, write only while no item is in flight.
// an item passes through the queue and then the output register before its
// result is on m_*. throughput: one item per cycle while m_tready keeps the
// output register free, set by the hold colour update in the back end which
// owns the colour table.
// a two-entry queue separates classification from resolution, so s_tready
// stays high while one result waits on a stalled receiver; with the queue full
// s_tready drops until m_tready returns.
// reset clears the colour table, hold colour, mode registers and queue.
module bitplane_colour_resolver #(
    parameter int QUEUE_DEPTH = brc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // plane_bits, lowres_pos, vert_window, hires, plane_count, line_start,
    // colour_slot, colour_value, zero fill
    input  logic [brc_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rgb, zero fill
    output logic [brc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import brc_pkg::*;

    item_t             front_item;
    item_t             head_item;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              push;
    logic [RGB_W-1:0]  rgb;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;

    // classify incoming items
    brc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .item      (front_item)
    );

    // queue between front and back
    brc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // resolve colours
    brc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .rgb      (rgb)
    );

    assign m_tdata = {{(M_TDATA_W - RGB_W){1'b0}}, rgb};

endmodule

FILE: sv/brc_front.sv
module brc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [brc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tuser,
    input  logic [brc_pkg::S_TDATA_W-1:0]    s_tdata,
    output brc_pkg::item_t                   item
);
    import brc_pkg::*;

    logic                  dual_pf_reg;
    logic                  ham_en_reg;
    logic                  pf2_front_reg;
    logic [POS_W-1:0]      hwin_start_reg;
    logic [POS_W-1:0]      hwin_stop_reg;

    logic [PLANE_W-1:0]    plane_bits;
    logic [POS_W-1:0]      lowres_pos;
    logic                  vert_window;
    logic                  hires;
    logic [PCOUNT_W-1:0]   plane_count;
    logic                  line_start;
    logic [SLOT_W-1:0]     colour_slot;
    logic [RGB_W-1:0]      colour_value;

    logic [PCOUNT_W-1:0]   planes;
    logic [PLANE_W-1:0]    bits;
    logic                  outside;
    logic                  ham;
    logic [2:0]            pf1;
    logic [2:0]            pf2;
    logic [SLOT_W-1:0]     dpf_idx;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_pf_reg    <= 1'b0;
            ham_en_reg     <= 1'b0;
            pf2_front_reg  <= 1'b0;
            hwin_start_reg <= '0;
            hwin_stop_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DUAL_PF:    dual_pf_reg    <= cfg_data[0];
                REG_HAM_EN:     ham_en_reg     <= cfg_data[0];
                REG_PF2_FRONT:  pf2_front_reg  <= cfg_data[0];
                REG_HWIN_START: hwin_start_reg <= cfg_data;
                REG_HWIN_STOP:  hwin_stop_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // unpack the input transfer
    assign plane_bits   = s_tdata[5:0];
    assign lowres_pos   = s_tdata[14:6];
    assign vert_window  = s_tdata[15];
    assign hires        = s_tdata[16];
    assign plane_count  = s_tdata[19:17];
    assign line_start   = s_tdata[20];
    assign colour_slot  = s_tdata[25:21];
    assign colour_value = s_tdata[37:26];

    // clamp plane count and drop disabled planes
    always_comb
    begin
        planes = (plane_count > PCOUNT_W'(PLANE_W)) ? PCOUNT_W'(PLANE_W) : plane_count;
        for (int i = 0; i < PLANE_W; i++)
        begin
            bits[i] = plane_bits[i] & (PCOUNT_W'(i) < planes);
        end
    end

    // window test and mode selection
    assign outside = !vert_window || (lowres_pos < hwin_start_reg)
                     || (lowres_pos >= hwin_stop_reg);
    assign ham     = ham_en_reg && !hires && (planes >= PCOUNT_W'(5)) && !dual_pf_reg;

    // dual playfield priority
    always_comb
    begin
        pf1 = {bits[4], bits[2], bits[0]};
        pf2 = {bits[5], bits[3], bits[1]};
        if (pf2_front_reg)
        begin
            dpf_idx = (pf2 != 3'd0) ? {2'b01, pf2} : {2'b00, pf1};
        end
        else if (pf1 != 3'd0)
        begin
            dpf_idx = {2'b00, pf1};
        end
        else if (pf2 != 3'd0)
        begin
            dpf_idx = {2'b01, pf2};
        end
        else
        begin
            dpf_idx = '0;
        end
    end

    // classify the item for the back end
    always_comb
    begin
        item.line_start = 1'b0;
        item.idx        = bits[4:0];
        item.ham_ctl    = ham_ctl_t'(bits[5:4]);
        item.value      = colour_value;
        if (s_tuser)
        begin
            item.op  = OP_WRITE;
            item.idx = colour_slot;
        end
        else
        begin
            item.line_start = line_start;
            if (outside)
            begin
                item.op = OP_BLANK;
            end
            else if (dual_pf_reg)
            begin
                item.op  = OP_LOOKUP;
                item.idx = dpf_idx;
            end
            else if (ham)
            begin
                item.op  = OP_HAM;
                item.idx = {1'b0, bits[3:0]};
            end
            else if ((planes == PCOUNT_W'(PLANE_W)) && bits[5])
            begin
                item.op = OP_HALF;
            end
            else
            begin
                item.op = OP_LOOKUP;
            end
        end
    end

endmodule

FILE: sv/brc_queue.sv
module brc_queue #(
    parameter int DEPTH = brc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  brc_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output brc_pkg::item_t  head_item
);
    import brc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // pointer wrap
    always_comb
    begin
        head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_next;
            end
            if (pop)
            begin
                head_reg <= head_next;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_item;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[head_reg];

    // occupancy checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance");

endmodule

FILE: sv/brc_back.sv
module brc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  brc_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [brc_pkg::RGB_W-1:0]   rgb
);
    import brc_pkg::*;

    logic [RGB_W-1:0]  colour_table_reg [COLOUR_COUNT];
    logic [RGB_W-1:0]  hold_reg;
    logic [RGB_W-1:0]  hold_next;
    logic [RGB_W-1:0]  rgb_reg;
    logic [RGB_W-1:0]  rgb_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              out_free;
    logic              pixel;
    logic [RGB_W-1:0]  colour0;
    logic [RGB_W-1:0]  colour_sel;
    logic [RGB_W-1:0]  hold_base;
    logic [RGB_W-1:0]  ham_colour;
    logic [NIB_W-1:0]  nib;

    // take a colour write at once, and a pixel when the output register can hold the result
    assign out_free = !out_valid_reg || m_tready;
    assign pixel    = (q_item.op != OP_WRITE);
    assign q_pop    = q_valid && (!pixel || out_free);

    // palette reads
    assign colour0    = colour_table_reg[0];
    assign colour_sel = colour_table_reg[q_item.idx];
    assign hold_base  = q_item.line_start ? colour0 : hold_reg;
    assign nib        = q_item.idx[NIB_W-1:0];

    // hold-and-modify update
    always_comb
    begin
        case (q_item.ham_ctl)
            HAM_LOAD:  ham_colour = colour_sel;
            HAM_BLUE:  ham_colour = {hold_base[11:4], nib};
            HAM_RED:   ham_colour = {nib, hold_base[7:0]};
            HAM_GREEN: ham_colour = {hold_base[11:8], nib, hold_base[3:0]};
            default:   ham_colour = colour_sel;
        endcase
    end

    // resolve colour and next hold value
    always_comb
    begin
        hold_next = hold_reg;
        rgb_next  = rgb_reg;
        if (q_pop && pixel)
        begin
            hold_next = hold_base;
            case (q_item.op)
                OP_BLANK:
                begin
                    hold_next = colour0;
                    rgb_next  = colour0;
                end
                OP_HAM:
                begin
                    hold_next = ham_colour;
                    rgb_next  = ham_colour;
                end
                OP_HALF:   rgb_next = (colour_sel >> 1) & HALF_MASK;
                OP_LOOKUP: rgb_next = colour_sel;
                default:   rgb_next = rgb_reg;
            endcase
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop && pixel)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // colour table, hold colour and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLOUR_COUNT; i++)
            begin
                colour_table_reg[i] <= '0;
            end
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop && !pixel)
            begin
                colour_table_reg[q_item.idx] <= q_item.value;
            end
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign rgb      = rgb_reg;

    // back end checks
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !pixel && !out_valid_reg) |=> !out_valid_reg)
        else $error("colour write produced a result");

    a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && pixel) |=> out_valid_reg)
        else $error("pixel item gave no result");

    a_blank_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.op == OP_BLANK) |=> (hold_reg == rgb_reg))
        else $error("hold colour not reloaded outside window");

endmodule

FILE: tb/tb_bitplane_colour_resolver.sv
module tb_bitplane_colour_resolver;

    import brc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int TOTAL_ITEMS   = 1980;

    // item kind carried on s_tuser
    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_COLOUR = 1'b1
    } kind_t;

    // s_tdata layout, first member in the top bits so plane_bits lands at bit 0
    typedef struct packed {
        logic [RGB_W-1:0]    colour_value;
        logic [SLOT_W-1:0]   colour_slot;
        logic                line_start;
        logic [PCOUNT_W-1:0] plane_count;
        logic                hires;
        logic                vert_window;
        logic [POS_W-1:0]    lowres_pos;
        logic [PLANE_W-1:0]  plane_bits;
    } column_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_DUAL_PF;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predicted block state
    logic [RGB_W-1:0] palette [COLOUR_COUNT];
    logic [RGB_W-1:0] hold_rgb;
    logic             pf_dual;
    logic             ham_req;
    logic             pf2_first;
    logic [POS_W-1:0] win_lo;
    logic [POS_W-1:0] win_hi;

    // colours still owed by the block, oldest first
    logic [RGB_W-1:0] expected_rgb [$];
    logic [RGB_W-1:0] owed_rgb;
    column_t          acc_col;

    // stimulus control and bookkeeping
    logic             tx_idle_en   = 1'b1;
    logic             rx_idle_en   = 1'b1;
    int               rx_hold_left = 0;
    int               rx_stall_left = 0;
    logic [POS_W-1:0] stim_win_lo  = '0;
    int               items_sent   = 0;
    int               colour_writes = 0;
    int               results_checked = 0;
    int               modes_set    = 0;
    int               errors       = 0;
    int               cycle_count  = 0;

    bitplane_colour_resolver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d colours still owed", cycle_count,
                 expected_rgb.size());
        $display("[bitplane_colour_resolver] ERROR");
        $finish;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("mismatch: %s", msg);
    endfunction

    // colour of one pixel column, updates the hold colour as the block does
    function automatic logic [RGB_W-1:0] resolve_column(input column_t c);
        logic [PCOUNT_W-1:0] planes;
        logic [PLANE_W-1:0]  bits;
        logic                ham;
        logic                half;
        logic [2:0]          pf1;
        logic [2:0]          pf2;
        logic [SLOT_W-1:0]   idx;
        logic [RGB_W-1:0]    h;
        planes = (c.plane_count > 3'd6) ? 3'd6 : c.plane_count;
        // planes that are switched off read as zero
        bits = c.plane_bits & ((planes == 3'd6) ? 6'h3F : 6'((7'd1 << planes) - 7'd1));
        if (c.line_start)
            hold_rgb = palette[0];
        // outside either window shows the background and reloads the hold colour
        if (!c.vert_window || c.lowres_pos < win_lo || c.lowres_pos >= win_hi)
        begin
            hold_rgb = palette[0];
            return palette[0];
        end
        ham  = ham_req && !c.hires && planes >= 3'd5 && !pf_dual;
        half = planes == 3'd6 && !pf_dual && !ham;
        if (pf_dual)
        begin
            pf1 = {bits[4], bits[2], bits[0]};
            pf2 = {bits[5], bits[3], bits[1]};
            if (pf2_first)
                idx = (pf2 != 3'd0) ? {2'b01, pf2} : {2'b00, pf1};
            else if (pf1 != 3'd0)
                idx = {2'b00, pf1};
            else
                idx = (pf2 != 3'd0) ? {2'b01, pf2} : 5'd0;
            return palette[idx];
        end
        if (ham)
        begin
            case (ham_ctl_t'(bits[5:4]))
                HAM_LOAD:  h = palette[{1'b0, bits[3:0]}];
                HAM_BLUE:  h = {hold_rgb[11:4], bits[3:0]};
                HAM_RED:   h = {bits[3:0], hold_rgb[7:0]};
                HAM_GREEN: h = {hold_rgb[11:8], bits[3:0], hold_rgb[3:0]};
                default:   h = hold_rgb;
            endcase
            hold_rgb = h;
            return h;
        end
        if (half && bits[5])
            return (palette[bits[4:0]] >> 1) & HALF_MASK;
        return palette[bits[4:0]];
    endfunction

    // model follows every accepted item
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            acc_col = column_t'(s_tdata[$bits(column_t)-1:0]);
            if (s_tuser == KIND_COLOUR)
                palette[acc_col.colour_slot] = acc_col.colour_value;
            else
                expected_rgb.push_back(resolve_column(acc_col));
        end
    end

    // model follows every register write
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DUAL_PF:    pf_dual   = cfg_data[0];
                REG_HAM_EN:     ham_req   = cfg_data[0];
                REG_PF2_FRONT:  pf2_first = cfg_data[0];
                REG_HWIN_START: win_lo    = cfg_data[POS_W-1:0];
                REG_HWIN_STOP:  win_hi    = cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // compare each result transfer with the oldest owed colour
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rgb.size() == 0)
                note_error($sformatf("rgb %h arrived with nothing owed", m_tdata[RGB_W-1:0]));
            else
            begin
                owed_rgb = expected_rgb.pop_front();
                results_checked++;
                if (m_tdata[RGB_W-1:0] !== owed_rgb)
                    note_error($sformatf("rgb expected %h got %h", owed_rgb,
                                         m_tdata[RGB_W-1:0]));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left != 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_idle_en && $urandom_range(0, 9) == 0)
        begin
            m_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 10);
        end
        else
            m_tready <= 1'b1;
    end

    function automatic column_t random_column();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return column_t'(r[$bits(column_t)-1:0]);
    endfunction

    // one item transfer on s_*, with an optional gap in front
    task automatic send_item(input kind_t kind, input column_t c);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(c);
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (kind == KIND_COLOUR)
            colour_writes++;
    endtask

    task automatic write_colour(input logic [SLOT_W-1:0] slot, input logic [RGB_W-1:0] value);
        column_t c;
        c = random_column();
        c.colour_slot  = slot;
        c.colour_value = value;
        send_item(KIND_COLOUR, c);
    endtask

    task automatic send_pixel(input logic [PLANE_W-1:0] bits, input logic [POS_W-1:0] pos,
                              input logic vwin, input logic hires,
                              input logic [PCOUNT_W-1:0] planes, input logic lstart);
        column_t c;
        c = random_column();
        c.plane_bits  = bits;
        c.lowres_pos  = pos;
        c.vert_window = vwin;
        c.hires       = hires;
        c.plane_count = planes;
        c.line_start  = lstart;
        send_item(KIND_PIXEL, c);
    endtask

    // drop valid and let everything owed come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all five registers, back to back
    task automatic set_mode(input logic dpf, input logic ham, input logic p2f,
                            input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        cfg_reg_t              regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{REG_DUAL_PF, REG_HAM_EN, REG_PF2_FRONT, REG_HWIN_START, REG_HWIN_STOP};
        vals = '{CFG_DATA_W'(dpf), CFG_DATA_W'(ham), CFG_DATA_W'(p2f), lo, hi};
        for (int r = 0; r < 5; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        stim_win_lo = lo;
        modes_set++;
    endtask

    task automatic apply_random_mode();
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        case ($urandom_range(0, 9))
            0:
            begin
                lo = '0;
                hi = '1;
            end
            1:
            begin
                lo = '1;
                hi = '0;
            end
            2:
            begin
                lo = POS_W'($urandom);
                hi = lo;
            end
            3:
            begin
                lo = POS_W'($urandom);
                hi = POS_W'($urandom);
            end
            default:
            begin
                lo = POS_W'($urandom_range(0, 60));
                hi = POS_W'($urandom_range(300, 511));
            end
        endcase
        set_mode($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), lo, hi);
    endtask

    // one display line: consecutive columns, line start on the first,
    // with colour writes and stray items mixed in
    task automatic send_random_line();
        column_t             c;
        logic                line_hires;
        logic                line_vwin;
        logic [PCOUNT_W-1:0] line_planes;
        logic [POS_W-1:0]    line_pos;
        int                  len;
        line_hires = ($urandom_range(0, 3) == 0);
        line_vwin  = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: line_planes = 3'd6;
            4, 5:       line_planes = 3'd5;
            default:    line_planes = PCOUNT_W'($urandom);
        endcase
        if ($urandom_range(0, 1) != 0)
            line_pos = POS_W'($urandom);
        else
            line_pos = stim_win_lo - POS_W'($urandom_range(0, 6));
        len = $urandom_range(4, 40);
        for (int n = 0; n < len; n++)
        begin
            c = random_column();
            if ($urandom_range(0, 11) == 0)
                send_item(KIND_COLOUR, c);
            else if ($urandom_range(0, 19) == 0)
                send_item(KIND_PIXEL, c);
            else
            begin
                c.lowres_pos  = line_pos + POS_W'(n);
                c.hires       = line_hires;
                c.vert_window = line_vwin;
                c.plane_count = line_planes;
                c.line_start  = (n == 0);
                send_item(KIND_PIXEL, c);
            end
        end
    endtask

    // palette lookup, disabled planes, half-brite and both windows
    task automatic test_lookup_and_window();
        set_mode(1'b0, 1'b0, 1'b0, 9'd0, 9'd511);
        write_colour(5'd0, 12'h5A3);
        write_colour(5'd31, 12'hFFF);
        write_colour(5'd9, 12'hE4C);
        write_colour(5'd1, 12'h0F0);
        write_colour(5'd15, 12'h9B1);
        send_pixel(6'h1F, 9'd0, 1'b1, 1'b0, 3'd5, 1'b1);
        send_pixel(6'h3F, 9'd10, 1'b1, 1'b0, 3'd0, 1'b0);
        send_pixel(6'h3F, 9'd200, 1'b1, 1'b0, 3'd7, 1'b0);
        send_pixel(6'h21, 9'd201, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'h1F, 9'd202, 1'b0, 1'b0, 3'd5, 1'b0);
        send_pixel(6'h1F, 9'd511, 1'b1, 1'b0, 3'd5, 1'b0);
        wait_idle();
    endtask

    // dual playfield with either playfield in front; ham request is ignored
    task automatic test_dual_playfield();
        set_mode(1'b1, 1'b1, 1'b0, 9'd0, 9'd511);
        send_pixel(6'b000001, 9'd40, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'b000010, 9'd41, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'b000011, 9'd42, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'b000000, 9'd43, 1'b1, 1'b0, 3'd6, 1'b0);
        wait_idle();
        set_mode(1'b1, 1'b0, 1'b1, 9'd0, 9'd511);
        send_pixel(6'b000011, 9'd44, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'b010101, 9'd45, 1'b1, 1'b0, 3'd6, 1'b0);
        wait_idle();
    endtask

    // hold-and-modify: each control code, the fallbacks and the hold reload
    task automatic test_hold_and_modify();
        set_mode(1'b0, 1'b1, 1'b0, 9'd0, 9'd511);
        send_pixel({HAM_BLUE, 4'hA}, 9'd60, 1'b1, 1'b0, 3'd6, 1'b1);
        send_pixel({HAM_RED, 4'h3}, 9'd61, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel({HAM_GREEN, 4'hC}, 9'd62, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel({HAM_LOAD, 4'h1}, 9'd63, 1'b1, 1'b0, 3'd6, 1'b0);
        send_pixel(6'h3F, 9'd64, 1'b1, 1'b1, 3'd6, 1'b0);
        send_pixel(6'h0F, 9'd65, 1'b1, 1'b0, 3'd4, 1'b0);
        send_pixel(6'h1B, 9'd66, 1'b1, 1'b0, 3'd5, 1'b0);
        send_pixel({HAM_RED, 4'h4}, 9'd67, 1'b0, 1'b0, 3'd6, 1'b0);
        send_pixel({HAM_GREEN, 4'h7}, 9'd68, 1'b1, 1'b0, 3'd6, 1'b0);
        wait_idle();
    endtask

    // empty and inverted horizontal windows
    task automatic test_empty_window();
        set_mode(1'b0, 1'b1, 1'b0, 9'd100, 9'd100);
        send_pixel({HAM_BLUE, 4'h5}, 9'd100, 1'b1, 1'b0, 3'd6, 1'b0);
        wait_idle();
        set_mode(1'b0, 1'b0, 1'b1, 9'd511, 9'd0);
        send_pixel(6'h1F, 9'd300, 1'b1, 1'b0, 3'd5, 1'b0);
        wait_idle();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        set_mode(1'b0, 1'b1, 1'b0, 9'd0, 9'd511);
        @(negedge clk);
        rx_hold_left = 60;
        @(posedge clk);
        send_random_line();
        send_random_line();
        wait_idle();
        tx_idle_en = 1'b1;
    endtask

    // random lines under random settings, draining before each change
    task automatic test_random_lines(input int upto);
        int next_mode_at;
        next_mode_at = items_sent;
        while (items_sent < upto)
        begin
            if (items_sent >= next_mode_at)
            begin
                wait_idle();
                apply_random_mode();
                next_mode_at = items_sent + $urandom_range(80, 160);
            end
            send_random_line();
            if ($urandom_range(0, 9) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate(input int upto);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_mode(1'b0, 1'b1, 1'b0, 9'd0, 9'd400);
        while (items_sent < upto)
            send_random_line();
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < COLOUR_COUNT; i++)
            palette[i] = '0;
        hold_rgb  = '0;
        pf_dual   = 1'b0;
        ham_req   = 1'b0;
        pf2_first = 1'b0;
        win_lo    = '0;
        win_hi    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_and_window();
        test_dual_playfield();
        test_hold_and_modify();
        test_empty_window();
        test_backpressure();
        test_random_lines(RANDOM_ITEMS);
        test_full_rate(TOTAL_ITEMS);

        if (expected_rgb.size() != 0)
            note_error($sformatf("%0d colours never arrived", expected_rgb.size()));
        $display("sent %0d items (%0d colour writes) over %0d mode settings",
                 items_sent, colour_writes, modes_set);
        $display("checked %0d pixel colours, %0d failures, %0d cycles",
                 results_checked, errors, cycle_count);
        if (errors == 0)
            $display("[bitplane_colour_resolver] OK");
        else
            $display("[bitplane_colour_resolver] ERROR");
        $finish;
    end

endmodule
